### sv/gwwm_pkg.sv
package gwwm_pkg;

	// default string length limit
	localparam int MAX_CHARS_DEF = 4096;

	// character classes
	localparam logic [1:0] CLS_ORDINARY = 2'd0;
	localparam logic [1:0] CLS_SPACE    = 2'd1;
	localparam logic [1:0] CLS_NEWLINE  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_MAX_LINE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_HORIZONTAL_SCALE = 2'd1;
	localparam logic [1:0] REG_LINE_SPACING     = 2'd2;
	localparam logic [1:0] REG_GLYPH_HEIGHT     = 2'd3;

	// register reset values
	localparam logic [15:0] MAX_LINE_WIDTH_RST   = 16'd0;
	localparam logic [15:0] HORIZONTAL_SCALE_RST = 16'd256;
	localparam logic [15:0] LINE_SPACING_RST     = 16'd256;
	localparam logic [7:0]  GLYPH_HEIGHT_RST     = 8'd16;

	// saturation limits
	localparam logic [15:0] WIDTH_SAT  = 16'hFFFF;
	localparam logic [12:0] LINES_SAT  = 13'h1FFF;
	localparam logic [27:0] HEIGHT_SAT = 28'hFFFFFFF;

	typedef struct packed {
		logic [1:0] char_class;
		logic [7:0] advance;
		logic       last_char;
	} gwwm_in_t;

	typedef struct packed {
		logic [11:0] char_index;
		logic        break_flag;
		logic [11:0] break_index;
		logic        final_flag;
		logic [15:0] total_width;
		logic [12:0] line_count;
		logic [27:0] total_height;
	} gwwm_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic step;
		logic mul1;
		logic mul2;
	} gwwm_cmd_t;

endpackage

### sv/gwwm_ctrl.sv
module gwwm_ctrl
	import gwwm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last_char,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output gwwm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL1 = 3'b010,
		ST_MUL2 = 3'b100
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// take a word when idle and the output register is free or emptying
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.step = accept;
	assign cmd.mul1 = (state_q == ST_MUL1);
	assign cmd.mul2 = (state_q == ST_MUL2);

	// sequencing: last word of a string runs two multiply steps for height
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && last_char) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= !last_char;
		end else if (state_q == ST_MUL2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/gwwm_dp.sv
module gwwm_dp
	import gwwm_pkg::*;
#(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  gwwm_cmd_t   cmd,
	input  gwwm_in_t    in_word,
	output gwwm_out_t   out_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PW = $clog2(MAX_CHARS);
	localparam int IW = (PW > 12) ? PW : 12;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_CHARS - 1);

	// configuration registers
	logic [15:0] max_w_q, hscale_q, spacing_q;
	logic [7:0]  gheight_q;

	// string state
	logic [PW-1:0] pos_q;
	logic [15:0]   line_q, word_q, widest_q;
	logic [11:0]   si_q;
	logic [7:0]    sa_q, prev_q;
	logic [12:0]   lines_q;

	// result and height product
	gwwm_out_t   res_q;
	logic [20:0] prod_s1;
	logic [36:0] prod2;
	logic [28:0] height;

	// step logic
	logic [IW-1:0] pos_ext;
	logic [11:0]   idx, idx_m1, si_cur, si_n, bidx;
	logic [7:0]    adv, sa_cur, sa_n;
	logic [15:0]   w1, l1, w2, sum, lw_n, ww_n, wid_n, wid_f, cand, tail;
	logic [31:0]   scaled;
	logic          brk, cnt, widen_en;
	logic [12:0]   lines_n, lines_f;

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? WIDTH_SAT : s[15:0];
	endfunction

	function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? (a - b) : 16'd0;
	endfunction

	assign pos_ext = IW'(pos_q);
	assign idx     = pos_ext[11:0];
	assign idx_m1  = idx - 12'd1;
	assign adv     = in_word.advance;

	// one character: width update, wrap test, break choice
	always_comb begin
		sa_cur   = (pos_q == '0) ? adv : sa_q;
		si_cur   = si_q;
		brk      = 1'b0;
		cnt      = 1'b0;
		bidx     = 12'd0;
		widen_en = 1'b0;
		cand     = 16'd0;
		w1       = sat_add(word_q, {8'd0, adv});
		l1       = line_q;
		w2       = w1;
		sum      = 16'd0;
		scaled   = 32'd0;
		lw_n     = line_q;
		ww_n     = word_q;
		sa_n     = sa_cur;
		si_n     = si_cur;
		if (in_word.char_class == CLS_NEWLINE) begin
			widen_en = 1'b1;
			cand     = sat_add(line_q, word_q);
			brk      = 1'b1;
			cnt      = 1'b1;
			bidx     = idx;
			sa_n     = adv;
			si_n     = idx;
			lw_n     = 16'd0;
			ww_n     = 16'd0;
		end else begin
			if (in_word.char_class == CLS_SPACE) begin
				sa_cur = adv;
				si_cur = idx;
				l1     = sat_add(line_q, w1);
				w2     = 16'd0;
			end
			lw_n   = l1;
			ww_n   = w2;
			sa_n   = sa_cur;
			si_n   = si_cur;
			sum    = sat_add(l1, w2);
			scaled = {16'd0, sum} * {16'd0, hscale_q};
			if ((max_w_q != 16'd0) && (scaled > {8'd0, max_w_q, 8'd0})) begin
				brk      = 1'b1;
				cnt      = 1'b1;
				widen_en = 1'b1;
				if (l1 == 16'd0) begin
					if (w2 == {8'd0, adv}) begin
						// lone letter: break after it
						cand = w2;
						bidx = idx;
						ww_n = 16'd0;
						sa_n = adv;
						si_n = idx;
					end else begin
						// no space on the line: break before this letter
						cand = sat_sub(w2, {8'd0, adv});
						ww_n = {8'd0, adv};
						bidx = idx_m1;
						sa_n = prev_q;
						si_n = idx_m1;
					end
				end else begin
					// break after the last space, dropping its width
					cand = sat_sub(l1, {8'd0, sa_cur});
					bidx = si_cur;
					lw_n = 16'd0;
					sa_n = adv;
					si_n = idx;
				end
			end
		end
		wid_n   = (widen_en && (cand > widest_q)) ? cand : widest_q;
		lines_n = (cnt && (lines_q < LINES_SAT)) ? (lines_q + 13'd1) : lines_q;
		// string end totals
		tail    = sat_add(lw_n, ww_n);
		wid_f   = (tail > wid_n) ? tail : wid_n;
		lines_f = (lines_n < LINES_SAT) ? (lines_n + 13'd1) : LINES_SAT;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_w_q   <= MAX_LINE_WIDTH_RST;
			hscale_q  <= HORIZONTAL_SCALE_RST;
			spacing_q <= LINE_SPACING_RST;
			gheight_q <= GLYPH_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_LINE_WIDTH:   max_w_q   <= cfg_data;
				REG_HORIZONTAL_SCALE: hscale_q  <= cfg_data;
				REG_LINE_SPACING:     spacing_q <= cfg_data;
				REG_GLYPH_HEIGHT:     gheight_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// string state update, cleared after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			line_q   <= 16'd0;
			word_q   <= 16'd0;
			widest_q <= 16'd0;
			si_q     <= 12'd0;
			sa_q     <= 8'd0;
			prev_q   <= 8'd0;
			lines_q  <= 13'd0;
		end else if (cmd.step) begin
			if (in_word.last_char) begin
				pos_q    <= '0;
				line_q   <= 16'd0;
				word_q   <= 16'd0;
				widest_q <= 16'd0;
				si_q     <= 12'd0;
				sa_q     <= 8'd0;
				prev_q   <= 8'd0;
				lines_q  <= 13'd0;
			end else begin
				if (pos_q < POS_LAST) pos_q <= pos_q + PW'(1);
				line_q   <= lw_n;
				word_q   <= ww_n;
				widest_q <= wid_n;
				si_q     <= si_n;
				sa_q     <= sa_n;
				prev_q   <= adv;
				lines_q  <= lines_n;
			end
		end
	end

	// height: lines * glyph height, then * spacing, scaled down and clamped
	assign prod2  = {16'd0, prod_s1} * {21'd0, spacing_q};
	assign height = prod2[36:8];

	// result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			res_q.char_index   <= idx;
			res_q.break_flag   <= brk;
			res_q.break_index  <= brk ? bidx : 12'd0;
			res_q.final_flag   <= in_word.last_char;
			res_q.total_width  <= in_word.last_char ? wid_f : 16'd0;
			res_q.line_count   <= in_word.last_char ? lines_f : 13'd0;
			res_q.total_height <= 28'd0;
		end else if (cmd.mul2) begin
			res_q.total_height <= height[28] ? HEIGHT_SAT : height[27:0];
		end
		if (cmd.mul1) begin
			prod_s1 <= {8'd0, res_q.line_count} * {13'd0, gheight_q};
		end
	end

	assign out_word = res_q;

endmodule

### sv/greedy_word_wrap_measure.sv
// Greedy word-wrap measurement. One character word per accepted input, each
// giving one output word with its index and any line end decided at it. While
// the output is taken, a character is accepted every cycle. The word marked
// last_char runs the step itself, then two registered multiply
// steps (line count times glyph height, then times line spacing) that form the
// total height; the output register holds one word, so input stalls only when
// a result is left untaken or during that height product. Configuration
// writes are taken at any time but belong between strings.
module greedy_word_wrap_measure
	import gwwm_pkg::*;
#(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  gwwm_in_t    in_word,
	output logic        out_valid,
	input  logic        out_ready,
	output gwwm_out_t   out_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gwwm_cmd_t cmd;

	// handshake and sequencing
	gwwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_char (in_word.last_char),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// widths, breaks and totals
	gwwm_dp #(
		.MAX_CHARS (MAX_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (in_word),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

### bench/greedy_word_wrap_measure_test.sv
`timescale 1ns / 100ps

module greedy_word_wrap_measure_test;
	import gwwm_pkg::*;

	// class code 3 has no name in the package; the block reads it as a letter
	localparam logic [1:0] CLS_UNKNOWN = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_CHARS = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	gwwm_in_t    in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	gwwm_out_t   out_word;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MAX_LINE_WIDTH;
	logic [15:0] cfg_data = '0;

	greedy_word_wrap_measure dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gwwm_in_t  pending_chars[$];
	gwwm_out_t expected_words[$];
	gwwm_out_t want_word;
	int        errors = 0;
	int        taken_words = 0;
	int        idle_cycles = 0;

	// shadow copy of the registers
	logic [15:0] max_w, h_scale, l_spacing;
	logic [7:0]  g_height;

	// shadow copy of the measuring state
	logic [11:0] pos, spc_idx;
	logic [15:0] line_w, word_w, widest;
	logic [7:0]  spc_adv, prev_adv;
	logic [12:0] lines_acc;

	function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? WIDTH_SAT : s[15:0];
	endfunction

	function automatic logic [15:0] sub_floor(logic [15:0] a, logic [15:0] b);
		return (a > b) ? a - b : 16'd0;
	endfunction

	function automatic void widen(logic [15:0] w);
		if (w > widest)
			widest = w;
	endfunction

	function automatic void bump_lines();
		if (lines_acc < LINES_SAT)
			lines_acc = lines_acc + 13'd1;
	endfunction

	function automatic void clear_line_state();
		pos = '0;
		line_w = '0;
		word_w = '0;
		spc_idx = '0;
		spc_adv = '0;
		prev_adv = '0;
		widest = '0;
		lines_acc = '0;
	endfunction

	// expected output word for one character, advancing the shadow state
	function automatic gwwm_out_t measure_char(gwwm_in_t c);
		gwwm_out_t   r;
		logic [11:0] idx;
		logic [11:0] bidx;
		logic        brk;
		logic [15:0] sum;
		logic [31:0] prod;
		logic [12:0] nlines;
		logic [40:0] hgt;
		idx = pos;
		brk = 1'b0;
		bidx = '0;
		if (idx == 12'd0)
			spc_adv = c.advance;
		if (c.char_class == CLS_NEWLINE) begin
			widen(add_sat(line_w, word_w));
			brk = 1'b1;
			bidx = idx;
			spc_adv = c.advance;
			spc_idx = idx;
			line_w = '0;
			word_w = '0;
			bump_lines();
		end else begin
			word_w = add_sat(word_w, {8'd0, c.advance});
			if (c.char_class == CLS_SPACE) begin
				spc_adv = c.advance;
				spc_idx = idx;
				line_w = add_sat(line_w, word_w);
				word_w = '0;
			end
			// exact wrap test against the Q8.8 scaled width
			if (max_w != 16'd0) begin
				sum = add_sat(line_w, word_w);
				prod = {16'd0, sum} * {16'd0, h_scale};
				if (prod > {8'd0, max_w, 8'd0}) begin
					bump_lines();
					brk = 1'b1;
					if (line_w == 16'd0) begin
						if (word_w == {8'd0, c.advance}) begin
							// lone letter: line ends after it
							widen(word_w);
							bidx = idx;
							word_w = '0;
							spc_adv = c.advance;
							spc_idx = idx;
						end else begin
							// no space on the line: break before this letter
							widen(sub_floor(word_w, {8'd0, c.advance}));
							word_w = {8'd0, c.advance};
							bidx = idx - 12'd1;
							spc_adv = prev_adv;
							spc_idx = idx - 12'd1;
						end
					end else begin
						// break after the last space, dropping its width
						widen(sub_floor(line_w, {8'd0, spc_adv}));
						bidx = spc_idx;
						line_w = '0;
						spc_adv = c.advance;
						spc_idx = idx;
					end
				end
			end
		end
		prev_adv = c.advance;

		r = '0;
		r.char_index = idx;
		r.break_flag = brk;
		r.break_index = brk ? bidx : 12'd0;
		r.final_flag = c.last_char;
		if (c.last_char) begin
			widen(add_sat(line_w, word_w));
			nlines = (lines_acc < LINES_SAT) ? lines_acc + 13'd1 : LINES_SAT;
			hgt = {28'd0, nlines} * {33'd0, g_height} * {25'd0, l_spacing};
			hgt = hgt >> 8;
			r.total_width = widest;
			r.line_count = nlines;
			r.total_height = (hgt > {13'd0, HEIGHT_SAT}) ? HEIGHT_SAT : hgt[27:0];
			clear_line_state();
		end else if (pos < 12'(MAX_CHARS_DEF - 1)) begin
			pos = pos + 12'd1;
		end
		return r;
	endfunction

	function automatic void check_field(string fname, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			errors++;
		end
	endfunction

	// sender: bursts of words with random gaps between them
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(measure_char(in_word));
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pending_chars.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					in_word <= pending_chars.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// receiver: stall pattern in modes, random hold-offs, one long hold-off
	int  rx_mode = 0;
	int  mode_left = 0;
	int  hold_left = 0;
	bit  long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (!long_hold_done && taken_words >= 200) begin
				hold_left = 150;
				long_hold_done = 1'b1;
			end else if (hold_left == 0 && $urandom_range(0, 499) == 0) begin
				hold_left = $urandom_range(30, 80);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// compare each taken word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			taken_words++;
			if (expected_words.size() == 0) begin
				$error("output word with nothing expected: char_index %0d",
					out_word.char_index);
				errors++;
			end else begin
				want_word = expected_words.pop_front();
				check_field("char_index", want_word.char_index, out_word.char_index);
				check_field("break_flag", want_word.break_flag, out_word.break_flag);
				check_field("break_index", want_word.break_index, out_word.break_index);
				check_field("final_flag", want_word.final_flag, out_word.final_flag);
				check_field("total_width", want_word.total_width, out_word.total_width);
				check_field("line_count", want_word.line_count, out_word.line_count);
				check_field("total_height", want_word.total_height,
					out_word.total_height);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAX_LINE_WIDTH:   max_w = val;
			REG_HORIZONTAL_SCALE: h_scale = val;
			REG_LINE_SPACING:     l_spacing = val;
			REG_GLYPH_HEIGHT:     g_height = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] mw, logic [15:0] hs, logic [15:0] ls,
			logic [7:0] gh);
		write_reg(REG_MAX_LINE_WIDTH, mw);
		write_reg(REG_HORIZONTAL_SCALE, hs);
		write_reg(REG_LINE_SPACING, ls);
		write_reg(REG_GLYPH_HEIGHT, {8'd0, gh});
	endtask

	// wait until every queued character is sent and every result is back
	task automatic wait_drained();
		while (pending_chars.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_char(logic [1:0] cls, logic [7:0] adv, logic last);
		gwwm_in_t c;
		c.char_class = cls;
		c.advance = adv;
		c.last_char = last;
		pending_chars.push_back(c);
	endtask

	// mark the most recent character as the end of its string
	task automatic close_string();
		gwwm_in_t c;
		c = pending_chars.pop_back();
		c.last_char = 1'b1;
		pending_chars.push_back(c);
	endtask

	function automatic logic [7:0] pick_adv();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		if (r == 2)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(3, 16));
	endfunction

	function automatic logic [1:0] pick_letter();
		return ($urandom_range(0, 19) == 0) ? CLS_UNKNOWN : CLS_ORDINARY;
	endfunction

	function automatic logic [15:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(16, 300));
	endfunction

	function automatic logic [15:0] pick_scale();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd1;
		if (r == 1)
			return 16'hFFFF;
		if (r == 2)
			return 16'd256;
		if (r == 3)
			return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(64, 1024));
	endfunction

	// words of letters split by spaces, now and then a newline or double space
	task automatic add_text();
		int words, w, k, len, sep;
		words = $urandom_range(1, 12);
		for (w = 0; w < words; w++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
			for (k = 0; k < len; k++)
				add_char(pick_letter(), pick_adv(), 1'b0);
			sep = $urandom_range(0, 9);
			if (sep == 0) begin
				add_char(CLS_NEWLINE, pick_adv(), 1'b0);
			end else if (sep == 1) begin
				add_char(CLS_SPACE, pick_adv(), 1'b0);
				add_char(CLS_SPACE, pick_adv(), 1'b0);
			end else if (sep < 9 || w < words - 1) begin
				add_char(CLS_SPACE, pick_adv(), 1'b0);
			end
		end
		close_string();
	endtask

	// fully random fields
	task automatic add_noise();
		int n, k;
		n = $urandom_range(1, 15);
		for (k = 0; k < n; k++)
			add_char(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0);
		close_string();
	endtask

	initial begin
		int p, k;
		max_w = MAX_LINE_WIDTH_RST;
		h_scale = HORIZONTAL_SCALE_RST;
		l_spacing = LINE_SPACING_RST;
		g_height = GLYPH_HEIGHT_RST;
		clear_line_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, wrap off: field extremes, every class, unknown class
		add_char(CLS_ORDINARY, 8'd0, 1'b0);
		add_char(CLS_ORDINARY, 8'd255, 1'b0);
		add_char(CLS_SPACE, 8'd0, 1'b0);
		add_char(CLS_SPACE, 8'd255, 1'b0);
		add_char(CLS_UNKNOWN, 8'd170, 1'b0);
		add_char(CLS_ORDINARY, 8'd85, 1'b0);
		add_char(CLS_NEWLINE, 8'd7, 1'b0);
		add_char(CLS_NEWLINE, 8'd1, 1'b1);
		wait_drained();

		// limit of 10 px at unit scale: each way a line can break
		set_config(16'd10, 16'd256, 16'hFFFF, 8'd255);
		add_char(CLS_ORDINARY, 8'd20, 1'b0);   // lone letter over the limit
		add_char(CLS_ORDINARY, 8'd4, 1'b0);
		add_char(CLS_ORDINARY, 8'd6, 1'b0);    // exactly at the limit
		add_char(CLS_ORDINARY, 8'd1, 1'b0);    // one over, no space
		add_char(CLS_SPACE, 8'd2, 1'b0);
		add_char(CLS_ORDINARY, 8'd5, 1'b0);
		add_char(CLS_ORDINARY, 8'd3, 1'b0);    // break after the space
		add_char(CLS_NEWLINE, 8'd0, 1'b0);
		add_char(CLS_SPACE, 8'd255, 1'b1);     // space alone over the limit
		wait_drained();

		// wrap off: word width, line width and their sum saturate
		set_config(16'd0, 16'd256, 16'hFFFF, 8'd255);
		for (k = 0; k < 270; k++)
			add_char(CLS_ORDINARY, 8'd255, 1'b0);
		add_char(CLS_SPACE, 8'd255, 1'b0);
		for (k = 0; k < 4; k++)
			add_char(CLS_ORDINARY, 8'd255, 1'b0);
		close_string();
		wait_drained();

		// one long string: many newlines with wrapped words between them
		set_config(16'd300, 16'd256, 16'hFFFF, 8'd255);
		for (k = 0; k < 60; k++) begin
			add_char(CLS_NEWLINE, 8'($urandom_range(0, 255)), 1'b0);
			if (k % 13 == 0) begin
				add_char(CLS_ORDINARY, 8'd90, 1'b0);
				add_char(CLS_ORDINARY, 8'd90, 1'b0);
				add_char(CLS_SPACE, 8'd20, 1'b0);
				add_char(CLS_ORDINARY, 8'd90, 1'b0);
				add_char(CLS_ORDINARY, 8'd90, 1'b0);
			end
		end
		add_char(CLS_ORDINARY, 8'd9, 1'b0);
		close_string();
		wait_drained();

		// random phases, each with its own register setting
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_config(16'd0, 16'd1, 16'd1, 8'd0);
				1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
				2: set_config(16'd1, 16'd1, pick_scale(), 8'd255);
				default: set_config(pick_limit(), pick_scale(), pick_scale(),
					8'($urandom_range(0, 255)));
			endcase
			while (pending_chars.size() < PHASE_CHARS) begin
				if ($urandom_range(0, 19) < 3)
					add_noise();
				else
					add_text();
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
